FILE: design/ac_conductivity_sequencer_core_defines.svh
// assertion helpers for the sequencer checker
`ifndef AC_CONDUCTIVITY_SEQUENCER_CORE_DEFINES_SVH
`define AC_CONDUCTIVITY_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, clocked by clk, quiet in reset
`define ACS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acs same-cycle check failed");

// next-cycle implication, clocked by clk, quiet in reset
`define ACS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acs next-cycle check failed");

`endif

FILE: design/acs_pkg.sv
package acs_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 10;
    localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
    localparam int TIME_BITS   = 32;
    localparam int WAIT_BITS   = 16;
    localparam int EC_BITS     = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CYCLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_PERIOD = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE      = 2'd2;

    typedef struct packed {
        logic [TIME_BITS-1:0]   now_ms;
        logic [SAMPLE_BITS-1:0] adc_sample;
    } sample_word_t;

    typedef struct packed {
        logic               drive_enable;
        logic               pos_drive;
        logic               neg_drive;
        logic               result_valid;
        logic [EC_BITS-1:0] ec_mean;
    } report_word_t;

    typedef struct packed {
        logic capture;
        logic step;
        logic div_start;
        logic div_run;
        logic div_finish;
        logic load_out;
    } acs_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } acs_status_t;

endpackage

FILE: design/acs_ctrl.sv
module acs_ctrl
    import acs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  acs_status_t status,
    output acs_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FINISH,
        S_EMIT
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = sample_valid;
                if (sample_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.step = 1'b1;
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_DIV:
            begin
                cmd.div_run = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.div_finish = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign sample_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/acs_datapath.sv
module acs_datapath
    import acs_pkg::*;
#(
    parameter int FRACTION_BITS = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sample_word_t             sample_word,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output logic                     report_valid,
    input  logic                     report_stall,
    output report_word_t             report_word,
    input  acs_cmd_t                 cmd,
    output acs_status_t              status
);

    localparam int TOT_BITS = SUM_BITS + 1 + FRACTION_BITS;
    localparam int DIV_BITS = COUNT_BITS + 1;
    localparam int STEP_W   = $clog2(TOT_BITS);

    localparam logic [3:0] PH_START      = 4'd0;
    localparam logic [3:0] PH_SETTLE     = 4'd1;
    localparam logic [3:0] PH_INIT       = 4'd2;
    localparam logic [3:0] PH_CHECK      = 4'd3;
    localparam logic [3:0] PH_WAIT_POS   = 4'd4;
    localparam logic [3:0] PH_SAMPLE_POS = 4'd5;
    localparam logic [3:0] PH_WAIT_NEG   = 4'd6;
    localparam logic [3:0] PH_SAMPLE_NEG = 4'd7;
    localparam logic [3:0] PH_REENABLE   = 4'd8;

    logic [COUNT_BITS-1:0] cycle_count_reg;
    logic [WAIT_BITS-1:0]  half_period_reg;
    logic [WAIT_BITS-1:0]  settle_reg;

    sample_word_t          in_reg;

    logic [3:0]            phase_reg, phase_next;
    logic [TIME_BITS-1:0]  mark_reg, mark_next;
    logic [COUNT_BITS-1:0] cycles_reg, cycles_next;
    logic [SUM_BITS-1:0]   pos_sum_reg, pos_sum_next;
    logic [SUM_BITS-1:0]   neg_sum_reg, neg_sum_next;
    logic                  en_reg, en_next;
    logic                  pos_reg, pos_next;
    logic                  neg_reg, neg_next;
    logic                  flag_reg, flag_next;
    logic [EC_BITS-1:0]    held_reg;

    logic [DIV_BITS-1:0]   rem_reg;
    logic [TOT_BITS-1:0]   quo_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIV_BITS:0]     trial;
    logic                  trial_ok;
    logic [DIV_BITS-1:0]   divisor;
    logic [TOT_BITS-1:0]   dividend;

    logic [TIME_BITS-1:0]  elapsed;
    logic                  settle_done;
    logic                  half_done;
    logic                  more_cycles;

    logic                  out_valid_reg;
    report_word_t          out_word_reg;

    assign elapsed     = in_reg.now_ms - mark_reg;
    assign settle_done = elapsed >= {{(TIME_BITS-WAIT_BITS){1'b0}}, settle_reg};
    assign half_done   = elapsed >= {{(TIME_BITS-WAIT_BITS){1'b0}}, half_period_reg};
    assign more_cycles = cycles_reg < cycle_count_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        mark_next    = mark_reg;
        cycles_next  = cycles_reg;
        pos_sum_next = pos_sum_reg;
        neg_sum_next = neg_sum_reg;
        en_next      = en_reg;
        pos_next     = pos_reg;
        neg_next     = neg_reg;
        flag_next    = 1'b0;
        case (phase_reg)
            PH_SETTLE:
            begin
                if (settle_done)
                begin
                    phase_next = PH_INIT;
                end
            end
            PH_INIT:
            begin
                en_next      = 1'b1;
                cycles_next  = '0;
                pos_sum_next = '0;
                neg_sum_next = '0;
                phase_next   = PH_CHECK;
            end
            PH_CHECK:
            begin
                if (more_cycles)
                begin
                    pos_next   = 1'b1;
                    neg_next   = 1'b0;
                    mark_next  = in_reg.now_ms;
                    phase_next = PH_WAIT_POS;
                end
                else
                begin
                    en_next    = 1'b0;
                    flag_next  = 1'b1;
                    phase_next = PH_START;
                end
            end
            PH_WAIT_POS:
            begin
                if (half_done)
                begin
                    phase_next = PH_SAMPLE_POS;
                end
            end
            PH_SAMPLE_POS:
            begin
                pos_sum_next = pos_sum_reg + SUM_BITS'(in_reg.adc_sample);
                pos_next     = 1'b0;
                neg_next     = 1'b1;
                mark_next    = in_reg.now_ms;
                phase_next   = PH_WAIT_NEG;
            end
            PH_WAIT_NEG:
            begin
                if (half_done)
                begin
                    phase_next = PH_SAMPLE_NEG;
                end
            end
            PH_SAMPLE_NEG:
            begin
                neg_sum_next = neg_sum_reg + SUM_BITS'(in_reg.adc_sample);
                neg_next     = 1'b0;
                cycles_next  = cycles_reg + 1'b1;
                phase_next   = PH_REENABLE;
            end
            PH_REENABLE:
            begin
                en_next    = 1'b1;
                phase_next = PH_CHECK;
            end
            default:
            begin
                mark_next  = in_reg.now_ms;
                phase_next = PH_SETTLE;
            end
        endcase
    end

    assign divisor  = {cycles_reg, 1'b0};
    assign dividend = (TOT_BITS'(pos_sum_reg) + TOT_BITS'(neg_sum_reg)) << FRACTION_BITS;
    assign trial    = {rem_reg, quo_reg[TOT_BITS-1]};
    assign trial_ok = trial >= {1'b0, divisor};

    assign status.need_div = (phase_reg == PH_CHECK) && !more_cycles;
    assign status.div_last = (step_reg == STEP_W'(TOT_BITS - 1));
    assign status.out_free = !out_valid_reg || !report_stall;

    assign cfg_ready    = 1'b1;
    assign report_valid = out_valid_reg;
    assign report_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count_reg <= COUNT_BITS'(10);
            half_period_reg <= WAIT_BITS'(10);
            settle_reg      <= WAIT_BITS'(100);
            phase_reg       <= PH_START;
            mark_reg        <= '0;
            cycles_reg      <= '0;
            pos_sum_reg     <= '0;
            neg_sum_reg     <= '0;
            en_reg          <= 1'b0;
            pos_reg         <= 1'b0;
            neg_reg         <= 1'b0;
            flag_reg        <= 1'b0;
            held_reg        <= '0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_CYCLE_COUNT: cycle_count_reg <= cfg_data[COUNT_BITS-1:0];
                    CFG_HALF_PERIOD: half_period_reg <= cfg_data;
                    CFG_SETTLE:      settle_reg      <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.step)
            begin
                phase_reg   <= phase_next;
                mark_reg    <= mark_next;
                cycles_reg  <= cycles_next;
                pos_sum_reg <= pos_sum_next;
                neg_sum_reg <= neg_sum_next;
                en_reg      <= en_next;
                pos_reg     <= pos_next;
                neg_reg     <= neg_next;
                flag_reg    <= flag_next;
            end
            if (cmd.div_start)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_run)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.div_finish)
            begin
                if (cycles_reg == '0)
                begin
                    held_reg <= '0;
                end
                else if (quo_reg > TOT_BITS'({EC_BITS{1'b1}}))
                begin
                    held_reg <= {EC_BITS{1'b1}};
                end
                else
                begin
                    held_reg <= quo_reg[EC_BITS-1:0];
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!report_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= sample_word;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (cmd.div_run)
        begin
            rem_reg <= trial_ok ? DIV_BITS'(trial - {1'b0, divisor}) : trial[DIV_BITS-1:0];
            quo_reg <= {quo_reg[TOT_BITS-2:0], trial_ok};
        end
        if (cmd.load_out)
        begin
            out_word_reg.drive_enable <= en_reg;
            out_word_reg.pos_drive    <= pos_reg;
            out_word_reg.neg_drive    <= neg_reg;
            out_word_reg.result_valid <= flag_reg;
            out_word_reg.ec_mean      <= held_reg;
        end
    end

endmodule

FILE: design/ac_conductivity_sequencer_core.sv
// ac conductivity sequencer: one sequencer tick per input word
// sample channel: sample_valid / sample_stall, word carries now_ms and adc_sample
// report channel: report_valid / report_stall, one report word per sample word,
//   giving the pin levels after the tick, result_valid and the held ec_mean
// config channel: cfg_valid / cfg_ready (always ready), cfg_index 0 cycle count,
//   1 half period, 2 settle time; other indexes are ignored
// sequence: a sample word is captured in the idle state, its tick runs in the exec
//   state and the report word is registered in the emit state once the output
//   register is free; the next word is taken only after that load
// the tick that ends a measurement runs a restoring divide, one quotient bit a
//   cycle, for 23 + FRACTION_BITS quotient bits, before its report is emitted
// one word is in work at a time; sample_stall is high from acceptance until
//   its report is loaded into the output register
// a report that waits under report_stall holds; the next sample word is taken
//   and worked while it waits, and its report loads once the register frees
// reset: registers 10 / 10 / 100, sequencer at start, drive off, ec_mean 0,
//   no report pending
module ac_conductivity_sequencer_core
    import acs_pkg::*;
#(
    parameter int FRACTION_BITS = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  sample_word_t             sample_word,
    output logic                     report_valid,
    input  logic                     report_stall,
    output report_word_t             report_word,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    acs_cmd_t    cmd;
    acs_status_t status;

    acs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    acs_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_word  (sample_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report_word  (report_word),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

FILE: design/acs_checker.sv
`include "ac_conductivity_sequencer_core_defines.svh"

module acs_checker
    import acs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     sample_valid,
    input logic                     sample_stall,
    input logic                     report_valid,
    input logic                     report_stall,
    input report_word_t             report_word
);

    // stalled report word holds
    `ACS_ASSERT_NEXT(a_report_hold, report_valid && report_stall,
        report_valid && $stable(report_word))

    // one word in work at a time
    `ACS_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall)

    // a finished measurement has the drive released
    `ACS_ASSERT_NOW(a_done_released, report_valid && report_word.result_valid,
        !report_word.drive_enable)

    // both electrodes are never high together
    `ACS_ASSERT_NOW(a_phase_exclusive, report_valid,
        !(report_word.pos_drive && report_word.neg_drive))

endmodule

bind ac_conductivity_sequencer_core acs_checker u_acs_checker (.*);

FILE: tb/ac_conductivity_sequencer_checker.sv
module ac_conductivity_sequencer_checker
    import acs_pkg::*;
#(
    parameter int FRACTION_BITS = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    input  logic                     sample_stall,
    input  sample_word_t             sample_word,
    input  logic                     report_valid,
    input  logic                     report_stall,
    input  report_word_t             report_word,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       fail_count,
    output int                       pending,
    output int                       reports_checked,
    output int                       measurements_done
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SHOWN = 10;
    localparam logic [COUNT_BITS-1:0] CYCLES_AT_RESET = COUNT_BITS'(10);
    localparam logic [WAIT_BITS-1:0] HALF_AT_RESET = WAIT_BITS'(10);
    localparam logic [WAIT_BITS-1:0] SETTLE_AT_RESET = WAIT_BITS'(100);

    typedef enum logic [3:0] {
        SEQ_START,
        SEQ_SETTLE,
        SEQ_INIT,
        SEQ_CHECK,
        SEQ_WAIT_POS,
        SEQ_SAMPLE_POS,
        SEQ_WAIT_NEG,
        SEQ_SAMPLE_NEG,
        SEQ_REENABLE
    } seq_state_t;

    logic [COUNT_BITS-1:0] cycle_limit;
    logic [WAIT_BITS-1:0]  half_period;
    logic [WAIT_BITS-1:0]  settle_time;

    seq_state_t            seq_state;
    logic [TIME_BITS-1:0]  mark_ms;
    logic [COUNT_BITS-1:0] cycles_run;
    logic [SUM_BITS-1:0]   pos_sum;
    logic [SUM_BITS-1:0]   neg_sum;
    logic                  drive_en;
    logic                  pos_level;
    logic                  neg_level;
    logic [EC_BITS-1:0]    ec_held;

    report_word_t expected_reports[$];

    assign pending = expected_reports.size();

    function automatic logic waited(logic [TIME_BITS-1:0] now, logic [WAIT_BITS-1:0] span);
        logic [TIME_BITS-1:0] gone;
        gone = now - mark_ms;
        return gone >= TIME_BITS'(span);
    endfunction

    function automatic logic [EC_BITS-1:0] mean_conductivity();
        logic [63:0] total;
        logic [63:0] quotient;
        if (cycles_run == '0)
            return '0;
        total = (64'(pos_sum) + 64'(neg_sum)) << FRACTION_BITS;
        quotient = total / (64'(cycles_run) * 64'd2);
        if (quotient > 64'hFFFF)
            quotient = 64'hFFFF;
        return quotient[EC_BITS-1:0];
    endfunction

    function automatic report_word_t run_tick(sample_word_t w);
        report_word_t r;
        logic done;
        done = 1'b0;
        case (seq_state)
            SEQ_SETTLE:
                if (waited(w.now_ms, settle_time))
                    seq_state = SEQ_INIT;
            SEQ_INIT:
            begin
                drive_en = 1'b1;
                cycles_run = '0;
                pos_sum = '0;
                neg_sum = '0;
                seq_state = SEQ_CHECK;
            end
            SEQ_CHECK:
                if (cycles_run < cycle_limit)
                begin
                    pos_level = 1'b1;
                    neg_level = 1'b0;
                    mark_ms = w.now_ms;
                    seq_state = SEQ_WAIT_POS;
                end
                else
                begin
                    drive_en = 1'b0;
                    ec_held = mean_conductivity();
                    done = 1'b1;
                    seq_state = SEQ_START;
                end
            SEQ_WAIT_POS:
                if (waited(w.now_ms, half_period))
                    seq_state = SEQ_SAMPLE_POS;
            SEQ_SAMPLE_POS:
            begin
                pos_sum = pos_sum + SUM_BITS'(w.adc_sample);
                pos_level = 1'b0;
                neg_level = 1'b1;
                mark_ms = w.now_ms;
                seq_state = SEQ_WAIT_NEG;
            end
            SEQ_WAIT_NEG:
                if (waited(w.now_ms, half_period))
                    seq_state = SEQ_SAMPLE_NEG;
            SEQ_SAMPLE_NEG:
            begin
                neg_sum = neg_sum + SUM_BITS'(w.adc_sample);
                neg_level = 1'b0;
                cycles_run = cycles_run + 1'b1;
                seq_state = SEQ_REENABLE;
            end
            SEQ_REENABLE:
            begin
                drive_en = 1'b1;
                seq_state = SEQ_CHECK;
            end
            default:
            begin
                mark_ms = w.now_ms;
                seq_state = SEQ_SETTLE;
            end
        endcase
        r.drive_enable = drive_en;
        r.pos_drive = pos_level;
        r.neg_drive = neg_level;
        r.result_valid = done;
        r.ec_mean = ec_held;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        report_word_t want;
        if (!rst_n)
        begin
            cycle_limit = CYCLES_AT_RESET;
            half_period = HALF_AT_RESET;
            settle_time = SETTLE_AT_RESET;
            seq_state = SEQ_START;
            mark_ms = '0;
            cycles_run = '0;
            pos_sum = '0;
            neg_sum = '0;
            drive_en = 1'b0;
            pos_level = 1'b0;
            neg_level = 1'b0;
            ec_held = '0;
            expected_reports.delete();
            fail_count = 0;
            reports_checked = 0;
            measurements_done = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CYCLE_COUNT: cycle_limit = cfg_data[COUNT_BITS-1:0];
                    CFG_HALF_PERIOD: half_period = cfg_data[WAIT_BITS-1:0];
                    CFG_SETTLE:      settle_time = cfg_data[WAIT_BITS-1:0];
                    default:         ;
                endcase
            end

            if (sample_valid && !sample_stall)
                expected_reports.push_back(run_tick(sample_word));

            if (report_valid && !report_stall)
            begin
                reports_checked++;
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("unexpected report word: en %b pos %b neg %b valid %b ec %0d",
                                 report_word.drive_enable, report_word.pos_drive,
                                 report_word.neg_drive, report_word.result_valid,
                                 report_word.ec_mean);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (want.result_valid)
                        measurements_done++;
                    if (report_word.drive_enable !== want.drive_enable
                        || report_word.pos_drive !== want.pos_drive
                        || report_word.neg_drive !== want.neg_drive
                        || report_word.result_valid !== want.result_valid
                        || report_word.ec_mean !== want.ec_mean)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_SHOWN)
                        begin
                            $display("report mismatch: expected en %b pos %b neg %b valid %b ec %0d",
                                     want.drive_enable, want.pos_drive, want.neg_drive,
                                     want.result_valid, want.ec_mean);
                            $display("                 got      en %b pos %b neg %b valid %b ec %0d",
                                     report_word.drive_enable, report_word.pos_drive,
                                     report_word.neg_drive, report_word.result_valid,
                                     report_word.ec_mean);
                        end
                    end
                end
            end
        end
    end

endmodule

FILE: tb/ac_conductivity_sequencer_core_tb.sv
module ac_conductivity_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acs_pkg::*;

    localparam int FRACTION_BITS = 4;
    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     sample_valid = 1'b0;
    logic                     sample_stall;
    sample_word_t             sample_word = '0;
    logic                     report_valid;
    logic                     report_stall = 1'b0;
    report_word_t             report_word;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int reports_checked;
    int measurements_done;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int words_sent = 0;
    int settings_used = 0;
    int cycles_elapsed = 0;
    logic hold_trigger = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;
    logic [TIME_BITS-1:0] clock_ms = '0;

    ac_conductivity_sequencer_core #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_word(sample_word),
        .report_valid(report_valid),
        .report_stall(report_stall),
        .report_word(report_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    ac_conductivity_sequencer_checker #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_word(sample_word),
        .report_valid(report_valid),
        .report_stall(report_stall),
        .report_word(report_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .pending(pending),
        .reports_checked(reports_checked),
        .measurements_done(measurements_done)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles_elapsed++;
        if (cycles_elapsed > LIMIT_CYCLES)
        begin
            $display("ac_conductivity_sequencer_core verification failed");
            $finish;
        end
    end

    // report side, with one long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_trigger && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            report_stall <= 1'b1;
        end
        else
            report_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    task automatic send_sample(input logic [TIME_BITS-1:0] t, input logic [SAMPLE_BITS-1:0] a);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct)
                @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_word <= {t, a};
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic write_config(input logic [COUNT_BITS-1:0] cc,
                                input logic [WAIT_BITS-1:0] hp,
                                input logic [WAIT_BITS-1:0] st);
        logic [CFG_IDX_BITS-1:0] idx [3];
        logic [CFG_DATA_BITS-1:0] val [3];
        idx = '{CFG_CYCLE_COUNT, CFG_HALF_PERIOD, CFG_SETTLE};
        val = '{CFG_DATA_BITS'(cc), hp, st};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // stop offering, let every report come back, then let the core idle
    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic run_phase(input int mode, input logic [COUNT_BITS-1:0] cc,
                             input logic [WAIT_BITS-1:0] hp, input logic [WAIT_BITS-1:0] st,
                             input int words, input logic squeeze);
        int max_wait;
        int r;
        case (mode)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
            default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
        endcase
        max_wait = (hp > st) ? int'(hp) : int'(st);
        write_config(cc, hp, st);
        if (squeeze)
            hold_trigger <= 1'b1;
        repeat (words)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                clock_ms = clock_ms + TIME_BITS'($urandom_range(0, 2));
            else if (r < 95)
                clock_ms = clock_ms + TIME_BITS'($urandom_range(0, 2 * max_wait + 2));
            else
                clock_ms = $urandom;
            send_sample(clock_ms, SAMPLE_BITS'($urandom_range(0, 4095)));
        end
        drain();
    endtask

    initial
    begin
        logic [TIME_BITS-1:0] t;
        logic [COUNT_BITS-1:0] cc;
        logic [WAIT_BITS-1:0] hp;
        logic [WAIT_BITS-1:0] st;
        int words;
        logic squeeze;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero cycle count: finishes at once with a zero average
        write_config('0, '0, '0);
        send_sample(32'd5, 12'd0);
        send_sample(32'd5, 12'hFFF);
        send_sample(32'd6, 12'h555);
        send_sample(32'd6, 12'hAAA);
        drain();

        // widest waits across the timestamp wrap, full and empty samples
        write_config(COUNT_BITS'(1), 16'hFFFF, 16'hFFFF);
        t = 32'hFFFF_FF00;
        send_sample(t, 12'd1);
        send_sample(t + 32'd100, 12'd2);
        t = t + 32'd65535;
        send_sample(t, 12'd3);
        send_sample(t, 12'd4);
        t = t + 32'd1;
        send_sample(t, 12'd5);
        send_sample(t + 32'd65534, 12'd6);
        t = t + 32'd65535;
        send_sample(t, 12'd7);
        send_sample(t, 12'hFFF);
        t = t + 32'd65535;
        send_sample(t, 12'd8);
        send_sample(t, 12'd0);
        send_sample(t, 12'd9);
        send_sample(t, 12'd10);
        drain();
        clock_ms = t;

        for (int p = 0; p < 10; p++)
        begin
            cc = ($urandom_range(0, 9) == 0) ? '0 : COUNT_BITS'($urandom_range(1, 4));
            hp = WAIT_BITS'($urandom_range(0, 3));
            st = WAIT_BITS'($urandom_range(0, 5));
            words = 75;
            squeeze = 1'b0;
            if (p == 3)
            begin
                // longest count, left mid-measurement for the next phase to cut short
                cc = '1;
                hp = '0;
                st = '0;
                words = 60;
            end
            else if (p == 4)
                cc = COUNT_BITS'(1);
            else if (p == 6)
            begin
                hp = WAIT_BITS'($urandom_range(0, 65535));
                st = WAIT_BITS'($urandom_range(0, 65535));
            end
            else if (p == 8)
                squeeze = 1'b1;
            run_phase(p % 4, cc, hp, st, words, squeeze);
        end

        $display("sent %0d sample words across %0d register settings and all idle patterns",
                 words_sent, settings_used);
        $display("checked %0d report words, %0d completed measurements, %0d still owed",
                 reports_checked, measurements_done, pending);
        if (fail_count == 0 && pending == 0)
            $display("ac_conductivity_sequencer_core verification clean");
        else
            $display("ac_conductivity_sequencer_core verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/acs_pkg.sv
design/acs_ctrl.sv
design/acs_datapath.sv
design/ac_conductivity_sequencer_core.sv
design/acs_checker.sv
tb/ac_conductivity_sequencer_checker.sv
tb/ac_conductivity_sequencer_core_tb.sv
